// File: src/g2p_pkg.sv
// ----------------------------------------------------------------------------
// g2p_pkg
// Shared widths, calendar constants and month tables for the Gregorian to
// Persian date unit.
// ----------------------------------------------------------------------------
package g2p_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;

	// Day count since 1600-01-01 fits below 2**23 for any 14-bit year
	localparam int unsigned COUNT_W = 23;
	// 33-year cycle count and four-year cycle count
	localparam int unsigned NP_W    = 9;
	localparam int unsigned Q4_W    = 4;

	localparam logic [YEAR_W-1:0] GREG_BASE_YEAR   = 14'd1600;
	localparam logic [YEAR_W-1:0] JALALI_BASE_YEAR = 14'd979;
	// first day of the count lies 79 days after 1600-01-01 (plus one for day 1)
	localparam logic [COUNT_W-1:0] EPOCH_DAYS      = 23'd80;

	localparam logic [13:0] CYCLE33_DAYS   = 14'd12053;
	localparam logic [10:0] CYCLE4_DAYS    = 11'd1461;
	localparam logic [8:0]  YEAR_DAYS      = 9'd365;
	localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
	localparam logic [5:0]  CYCLE33_YEARS  = 6'd33;

	// x / 100 as (x * 5243) >> 19, exact for x below 16384
	localparam logic [12:0] DIV100_MUL     = 13'd5243;
	localparam int unsigned DIV100_SHIFT   = 19;
	localparam logic [6:0]  CENTURY        = 7'd100;

	// reciprocal estimates, floor(2**k / divisor): quotient is exact or one low
	localparam int unsigned CYCLE33_SHIFT  = 37;
	localparam logic [23:0] CYCLE33_RECIP  =
		24'((64'd1 << CYCLE33_SHIFT) / 64'd12053);
	localparam int unsigned CYCLE4_SHIFT   = 28;
	localparam logic [17:0] CYCLE4_RECIP   =
		18'((64'd1 << CYCLE4_SHIFT) / 64'd1461);

	// days before the first of each Gregorian month, common year
	function automatic logic [8:0] greg_cum(input logic [3:0] mi);
		logic [8:0] res;
		unique case (mi)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd59;
			4'd3:    res = 9'd90;
			4'd4:    res = 9'd120;
			4'd5:    res = 9'd151;
			4'd6:    res = 9'd181;
			4'd7:    res = 9'd212;
			4'd8:    res = 9'd243;
			4'd9:    res = 9'd273;
			4'd10:   res = 9'd304;
			4'd11:   res = 9'd334;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

	// days before the first of each Jalali month
	function automatic logic [8:0] jal_cum(input logic [3:0] mi);
		logic [8:0] res;
		unique case (mi)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd62;
			4'd3:    res = 9'd93;
			4'd4:    res = 9'd124;
			4'd5:    res = 9'd155;
			4'd6:    res = 9'd186;
			4'd7:    res = 9'd216;
			4'd8:    res = 9'd246;
			4'd9:    res = 9'd276;
			4'd10:   res = 9'd306;
			4'd11:   res = 9'd336;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

// File: src/gregorian_to_persian_date_unit.sv
// ----------------------------------------------------------------------------
// gregorian_to_persian_date_unit
// Converts one Gregorian date a cycle when nothing stalls into the matching Persian (Jalali) date.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries greg_year, greg_month and
//   greg_day; a transfer happens on a rising edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall) carries
//   persian_year, persian_month, persian_day and before_epoch in the same way.
//   Every input transfer yields exactly one output transfer, in order.
//   Throughput is one date per cycle when nothing stalls; the ten-stage
//   pipeline (day count, 33-year split, four-year split, year and month
//   split) ends in the result register that drives the outputs.
//   Dates before 1600-03-20 give before_epoch high and zero date fields.
//   When out_stall holds the result, the stages behind it keep filling any
//   empty slots; in_stall rises only once every stage holds a date.
//   Reset (arst_n low) empties the pipeline at once; no date is lost or
//   invented across the stall, only in-flight dates are dropped at reset.
// ----------------------------------------------------------------------------
module gregorian_to_persian_date_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [g2p_pkg::YEAR_W-1:0]    greg_year,
	input  logic [g2p_pkg::MONTH_W-1:0]   greg_month,
	input  logic [g2p_pkg::DAY_W-1:0]     greg_day,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [g2p_pkg::YEAR_W-1:0]    persian_year,
	output logic [g2p_pkg::MONTH_W-1:0]   persian_month,
	output logic [g2p_pkg::DAY_W-1:0]     persian_day,
	output logic                          before_epoch
);

	localparam int unsigned NSTAGE = 10;

	// ---------------------------------------------------------------- control
	// A stage advances when it is empty or the stage in front advances.
	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] adv;

	always_comb begin
		adv[NSTAGE] = !vld_q[NSTAGE] || !out_stall;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = vld_q[NSTAGE];

	// ---------------------------------------------------------- stage 1: input
	logic [g2p_pkg::YEAR_W-1:0]  year_s1;
	logic [g2p_pkg::MONTH_W-1:0] month_s1;
	logic [g2p_pkg::DAY_W-1:0]   day_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			year_s1  <= greg_year;
			month_s1 <= greg_month;
			day_s1   <= greg_day;
		end
	end

	// ------------------------------------------- stage 2: leap and century terms
	logic [g2p_pkg::YEAR_W-1:0] gy;
	logic [3:0]  mi;
	logic [14:0] gy_p3, gy_p99, gy_p399;
	logic [27:0] c100_prod, c400_prod, q100_prod;
	logic [7:0]  q100;
	logic        div100, leap;
	logic [8:0]  cum;

	always_comb begin
		gy = year_s1 - g2p_pkg::GREG_BASE_YEAR;
		// month zero reads as January, months past twelve as December
		if (month_s1 == 4'd0) begin
			mi = 4'd0;
		end else if (month_s1 > 4'd12) begin
			mi = 4'd11;
		end else begin
			mi = month_s1 - 4'd1;
		end
		gy_p3     = 15'(gy) + 15'd3;
		gy_p99    = 15'(gy) + 15'd99;
		gy_p399   = 15'(gy) + 15'd399;
		c100_prod = 28'(gy_p99) * 28'(g2p_pkg::DIV100_MUL);
		c400_prod = 28'(gy_p399[14:2]) * 28'(g2p_pkg::DIV100_MUL);
		q100_prod = 28'(gy) * 28'(g2p_pkg::DIV100_MUL);
		q100      = 8'(q100_prod >> g2p_pkg::DIV100_SHIFT);
		div100    = (14'(q100) * 14'(g2p_pkg::CENTURY)) == gy;
		leap      = (gy[1:0] == 2'd0) && (!div100 || (q100[1:0] == 2'd0));
		cum       = g2p_pkg::greg_cum(mi) + 9'((leap && (mi > 4'd1)) ? 1 : 0);
	end

	logic [g2p_pkg::YEAR_W-1:0] gy_s2;
	logic [12:0] ceil4_s2;
	logic [7:0]  c100_s2, c400_s2;
	logic [8:0]  cum_s2;
	logic [g2p_pkg::DAY_W-1:0] day_s2;
	logic        early_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			gy_s2    <= gy;
			ceil4_s2 <= gy_p3[14:2];
			c100_s2  <= 8'(c100_prod >> g2p_pkg::DIV100_SHIFT);
			c400_s2  <= 8'(c400_prod >> g2p_pkg::DIV100_SHIFT);
			cum_s2   <= cum;
			day_s2   <= day_s1;
			early_s2 <= year_s1 < g2p_pkg::GREG_BASE_YEAR;
		end
	end

	// -------------------------------------------------- stage 3: day count
	logic [g2p_pkg::COUNT_W-1:0] days;

	always_comb begin
		days = 23'(gy_s2) * 23'(g2p_pkg::YEAR_DAYS) + 23'(ceil4_s2) - 23'(c100_s2)
			+ 23'(c400_s2) + 23'(cum_s2) + 23'(day_s2);
	end

	logic [g2p_pkg::COUNT_W-1:0] d_s3;
	logic                        early_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			d_s3     <= days - g2p_pkg::EPOCH_DAYS;
			early_s3 <= early_s2 || (days < g2p_pkg::EPOCH_DAYS);
		end
	end

	// ---------------------------------- stage 4: 33-year cycle estimate
	logic [46:0] np_prod;
	assign np_prod = 47'(d_s3) * 47'(g2p_pkg::CYCLE33_RECIP);

	logic [g2p_pkg::NP_W-1:0]    np_s4;
	logic [g2p_pkg::COUNT_W-1:0] d_s4;
	logic                        early_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			np_s4    <= g2p_pkg::NP_W'(np_prod >> g2p_pkg::CYCLE33_SHIFT);
			d_s4     <= d_s3;
			early_s4 <= early_s3;
		end
	end

	// ---------------------------------- stage 5: 33-year remainder estimate
	logic [g2p_pkg::COUNT_W-1:0] r0_full;
	assign r0_full = d_s4 - 23'(np_s4) * 23'(g2p_pkg::CYCLE33_DAYS);

	logic [14:0]              r0_s5;
	logic [g2p_pkg::NP_W-1:0] np_s5;
	logic                     early_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			r0_s5    <= r0_full[14:0];
			np_s5    <= np_s4;
			early_s5 <= early_s4;
		end
	end

	// ---------------------------------- stage 6: correct the estimate
	logic [13:0]              r_s6;
	logic [g2p_pkg::NP_W-1:0] np_s6;
	logic                     early_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			if (r0_s5 >= 15'(g2p_pkg::CYCLE33_DAYS)) begin
				np_s6 <= np_s5 + g2p_pkg::NP_W'(1);
				r_s6  <= 14'(r0_s5 - 15'(g2p_pkg::CYCLE33_DAYS));
			end else begin
				np_s6 <= np_s5;
				r_s6  <= r0_s5[13:0];
			end
			early_s6 <= early_s5;
		end
	end

	// ---------------------------------- stage 7: four-year cycle estimate
	logic [31:0] q4_prod;
	assign q4_prod = 32'(r_s6) * 32'(g2p_pkg::CYCLE4_RECIP);

	logic [g2p_pkg::Q4_W-1:0] q4_s7;
	logic [13:0]              r_s7;
	logic [g2p_pkg::NP_W-1:0] np_s7;
	logic                     early_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			q4_s7    <= g2p_pkg::Q4_W'(q4_prod >> g2p_pkg::CYCLE4_SHIFT);
			r_s7     <= r_s6;
			np_s7    <= np_s6;
			early_s7 <= early_s6;
		end
	end

	// ---------------------------------- stage 8: four-year remainder
	logic [11:0] r1;
	assign r1 = 12'(r_s7 - 14'(q4_s7) * 14'(g2p_pkg::CYCLE4_DAYS));

	logic [g2p_pkg::Q4_W-1:0] q4_s8;
	logic [10:0]              r4_s8;
	logic [g2p_pkg::NP_W-1:0] np_s8;
	logic                     early_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			if (r1 >= 12'(g2p_pkg::CYCLE4_DAYS)) begin
				q4_s8 <= q4_s7 + g2p_pkg::Q4_W'(1);
				r4_s8 <= 11'(r1 - 12'(g2p_pkg::CYCLE4_DAYS));
			end else begin
				q4_s8 <= q4_s7;
				r4_s8 <= r1[10:0];
			end
			np_s8    <= np_s7;
			early_s8 <= early_s7;
		end
	end

	// ---------------------------------- stage 9: year within the cycle
	// The first year of each four-year run is the long one.
	logic [10:0] e;
	logic [1:0]  yq;
	logic [8:0]  dy;
	logic [g2p_pkg::YEAR_W-1:0] jy;

	always_comb begin
		e = r4_s8 - 11'd1;
		if (r4_s8 < 11'(g2p_pkg::LEAP_YEAR_DAYS)) begin
			yq = 2'd0;
			dy = r4_s8[8:0];
		end else begin
			if (e >= 11'(3 * g2p_pkg::YEAR_DAYS)) begin
				yq = 2'd3;
			end else if (e >= 11'(2 * g2p_pkg::YEAR_DAYS)) begin
				yq = 2'd2;
			end else begin
				yq = 2'd1;
			end
			dy = 9'(e - 11'(yq) * 11'(g2p_pkg::YEAR_DAYS));
		end
		jy = g2p_pkg::JALALI_BASE_YEAR
			+ 14'(14'(np_s8) * 14'(g2p_pkg::CYCLE33_YEARS))
			+ 14'({q4_s8, 2'b00}) + 14'(yq);
	end

	logic [g2p_pkg::YEAR_W-1:0] jy_s9;
	logic [8:0]                 dy_s9;
	logic                       early_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			jy_s9    <= jy;
			dy_s9    <= dy;
			early_s9 <= early_s8;
		end
	end

	// ---------------------------------- stage 10: month walk, result register
	logic [3:0] idx;

	always_comb begin
		idx = 4'd0;
		for (int j = 1; j < 12; j++) begin
			if (dy_s9 >= g2p_pkg::jal_cum(4'(j))) begin
				idx = 4'(j);
			end
		end
	end

	logic [g2p_pkg::YEAR_W-1:0]  year_s10;
	logic [g2p_pkg::MONTH_W-1:0] month_s10;
	logic [g2p_pkg::DAY_W-1:0]   day_s10;
	logic                        early_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			// drop the computed date for anything before the count starts
			if (early_s9) begin
				year_s10  <= '0;
				month_s10 <= '0;
				day_s10   <= '0;
			end else begin
				year_s10  <= jy_s9;
				month_s10 <= idx + 4'd1;
				day_s10   <= 5'(dy_s9 - g2p_pkg::jal_cum(idx) + 9'd1);
			end
			early_s10 <= early_s9;
		end
	end

	assign persian_year  = year_s10;
	assign persian_month = month_s10;
	assign persian_day   = day_s10;
	assign before_epoch  = early_s10;

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gregorian_to_persian_date_unit: drives Gregorian
// dates, works out the Jalali date of each transfer and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HALF_PERIOD  = 6;
	localparam int unsigned RESET_CYCLES = 5;
	// pipeline depth given at the head of the unit, with margin
	localparam int unsigned DRAIN_CYCLES = 30;
	// hold-off long enough to fill all ten stages several times over
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned LIMIT_CYCLES = 200000;

	// days before the first of each Gregorian month in a common year
	localparam int unsigned GREG_MONTH_START [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};
	// length of each Jalali month, Esfand taken as 29
	localparam int unsigned JALALI_MONTH_LEN [12] = '{
		31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30, 29
	};

	typedef struct packed {
		logic [g2p_pkg::YEAR_W-1:0]  year;
		logic [g2p_pkg::MONTH_W-1:0] month;
		logic [g2p_pkg::DAY_W-1:0]   day;
		logic                        before_epoch;
	} persian_date_t;

	logic                         clk;
	logic                         arst_n        = 1'b0;
	logic                         in_valid      = 1'b0;
	logic                         in_stall;
	logic [g2p_pkg::YEAR_W-1:0]   greg_year     = '0;
	logic [g2p_pkg::MONTH_W-1:0]  greg_month    = '0;
	logic [g2p_pkg::DAY_W-1:0]    greg_day      = '0;
	logic                         out_valid;
	logic                         out_stall     = 1'b0;
	logic [g2p_pkg::YEAR_W-1:0]   persian_year;
	logic [g2p_pkg::MONTH_W-1:0]  persian_month;
	logic [g2p_pkg::DAY_W-1:0]    persian_day;
	logic                         before_epoch;

	// traffic shaping, percentages out of a hundred
	int unsigned         idle_pct      = 0;
	int unsigned         stall_pct     = 0;
	// long hold-off requests, served by the stall process
	int unsigned         holds_asked   = 0;
	int unsigned         holds_served  = 0;
	int unsigned         hold_left     = 0;

	persian_date_t       pending_dates[$];
	int unsigned         error_count   = 0;
	int unsigned         cycle_count   = 0;

	gregorian_to_persian_date_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.greg_year     (greg_year),
		.greg_month    (greg_month),
		.greg_day      (greg_day),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.persian_year  (persian_year),
		.persian_month (persian_month),
		.persian_day   (persian_day),
		.before_epoch  (before_epoch)
	);

	initial begin
		clk = 1'b0;
		forever #(HALF_PERIOD) clk = ~clk;
	end

	// Work out the Jalali date for one Gregorian date. Count days from
	// 1600-01-01, move the origin to 1 Farvardin 979, then peel off 33-year
	// cycles, four-year cycles and single years before walking the months.
	function automatic persian_date_t persian_of(input logic [g2p_pkg::YEAR_W-1:0] y,
			input logic [g2p_pkg::MONTH_W-1:0] m, input logic [g2p_pkg::DAY_W-1:0] d);
		persian_date_t res;
		int unsigned   gy;
		int unsigned   mi;
		int unsigned   count;
		int unsigned   jy;
		int unsigned   mon;
		res = '0;
		if (y < 1600) begin
			// early year: flag only
			res.before_epoch = 1'b1;
			return res;
		end
		// month zero reads as January, anything past twelve as December
		if (m == 0)
			mi = 0;
		else if (m > 12)
			mi = 11;
		else
			mi = m - 1;
		gy = y - 1600;
		count = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
		count += GREG_MONTH_START[mi];
		if (mi > 1 && (((gy % 4) == 0 && (gy % 100) != 0) || (gy % 400) == 0))
			count += 1;
		// day zero is the day before the first; before 1600-03-20 is flagged
		if (count + d < 80) begin
			res.before_epoch = 1'b1;
			return res;
		end
		count = count + d - 80;
		jy = 979 + 33 * (count / 12053);
		count = count % 12053;
		jy += 4 * (count / 1461);
		count = count % 1461;
		if (count >= 366) begin
			jy += (count - 1) / 365;
			count = (count - 1) % 365;
		end
		mon = 0;
		while (mon < 11 && count >= JALALI_MONTH_LEN[mon]) begin
			count -= JALALI_MONTH_LEN[mon];
			mon++;
		end
		res.year  = g2p_pkg::YEAR_W'(jy);
		res.month = g2p_pkg::MONTH_W'(mon + 1);
		res.day   = g2p_pkg::DAY_W'(count + 1);
		return res;
	endfunction

	// Offer one date and hold it until the transfer. Valid is left high on
	// return so that back-to-back dates never drop it between transfers.
	task automatic send_date(input logic [g2p_pkg::YEAR_W-1:0] y,
			input logic [g2p_pkg::MONTH_W-1:0] m, input logic [g2p_pkg::DAY_W-1:0] d);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		greg_year  <= y;
		greg_month <= m;
		greg_day   <= d;
		do
			@(posedge clk);
		while (in_stall);
		pending_dates.push_back(persian_of(y, m, d));
	endtask

	// Drop valid and hold off until every expected result has arrived.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_traffic(input int unsigned idle, input int unsigned stall);
		idle_pct  <= idle;
		stall_pct <= stall;
		@(posedge clk);
	endtask

	// Mostly well-formed dates, some around the start of the count and some
	// raw bit patterns covering month zero, months past twelve and tiny years.
	task automatic send_random_dates(input int unsigned n);
		int unsigned                 kind;
		logic [g2p_pkg::YEAR_W-1:0]  y;
		logic [g2p_pkg::MONTH_W-1:0] m;
		logic [g2p_pkg::DAY_W-1:0]   d;
		repeat (n) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				y = g2p_pkg::YEAR_W'($urandom_range(9999, 1600));
				m = g2p_pkg::MONTH_W'($urandom_range(12, 1));
				d = g2p_pkg::DAY_W'($urandom_range(31, 1));
			end else if (kind < 80) begin
				y = g2p_pkg::YEAR_W'($urandom_range(9999, 1600));
				m = g2p_pkg::MONTH_W'($urandom_range(12, 1));
				d = g2p_pkg::DAY_W'($urandom_range(31, 28));
			end else if (kind < 88) begin
				y = g2p_pkg::YEAR_W'($urandom_range(1601, 1599));
				m = g2p_pkg::MONTH_W'($urandom_range(4, 0));
				d = g2p_pkg::DAY_W'($urandom_range(31, 0));
			end else begin
				y = g2p_pkg::YEAR_W'($urandom());
				m = g2p_pkg::MONTH_W'($urandom());
				d = g2p_pkg::DAY_W'($urandom());
			end
			send_date(y, m, d);
		end
	endtask

	// Extremes of every field and each corner of the conversion.
	task automatic test_corner_dates();
		send_date(14'd0, 4'd0, 5'd0);          // all-zero pattern
		send_date(14'd1599, 4'd12, 5'd31);     // early year
		send_date(14'd1600, 4'd1, 5'd1);       // first day of the count
		send_date(14'd1600, 4'd3, 5'd19);      // last flagged day
		send_date(14'd1600, 4'd3, 5'd20);      // 1 Farvardin 979
		send_date(14'd1600, 4'd3, 5'd0);       // day zero near the start
		send_date(14'd1600, 4'd4, 5'd0);       // day zero past the start
		send_date(14'd1600, 4'd0, 5'd31);      // month zero
		send_date(14'd2024, 4'd15, 5'd31);     // month past twelve
		send_date(14'd2023, 4'd2, 5'd31);      // day past month end
		send_date(14'd2000, 4'd2, 5'd29);      // leap century
		send_date(14'd1900, 4'd3, 5'd1);       // common century
		send_date(14'd2024, 4'd3, 5'd20);      // Nowruz, leap year
		send_date(14'd2025, 4'd3, 5'd21);      // Nowruz
		send_date(14'd2025, 4'd3, 5'd20);      // last day of Esfand
		send_date(14'd2024, 4'd12, 5'd31);     // year end
		send_date(14'd9999, 4'd12, 5'd31);     // nominal top
		send_date(14'd16383, 4'd15, 5'd31);    // every input bit set
		send_date(14'd16383, 4'd1, 5'd1);      // largest year
		send_date(14'd10922, 4'd10, 5'd10);    // mixed bit pattern
		send_date(14'd5461, 4'd5, 5'd21);      // complementary pattern
		wait_for_results();
	endtask

	task automatic test_full_rate();
		set_traffic(0, 0);
		send_random_dates(400);
		wait_for_results();
	endtask

	task automatic test_sender_gaps();
		set_traffic(51, 0);
		send_random_dates(400);
		wait_for_results();
	endtask

	task automatic test_receiver_stalls();
		set_traffic(0, 51);
		send_random_dates(400);
		wait_for_results();
	endtask

	task automatic test_mixed_idling();
		set_traffic(14, 14);
		send_random_dates(400);
		wait_for_results();
	endtask

	// Hold the output for a long stretch while dates keep coming, so the
	// pipeline fills and pushes back on the input.
	task automatic test_back_pressure();
		set_traffic(0, 0);
		holds_asked <= holds_asked + 1;
		send_random_dates(40);
		wait_for_results();
	endtask

	// Receiver: serve any long hold-off first, otherwise stall at random.
	always @(posedge clk) begin
		if (holds_asked != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			out_stall    <= 1'b1;
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
		end
	end

	// Check each output transfer against the oldest expected date.
	always @(posedge clk) begin
		persian_date_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dates.size() == 0) begin
				error_count++;
				$error("unexpected result: year %0d month %0d day %0d flag %0b",
					persian_year, persian_month, persian_day, before_epoch);
			end else begin
				want = pending_dates.pop_front();
				if (persian_year !== want.year) begin
					error_count++;
					$error("persian_year: expected %0d, got %0d", want.year, persian_year);
				end
				if (persian_month !== want.month) begin
					error_count++;
					$error("persian_month: expected %0d, got %0d", want.month,
						persian_month);
				end
				if (persian_day !== want.day) begin
					error_count++;
					$error("persian_day: expected %0d, got %0d", want.day, persian_day);
				end
				if (before_epoch !== want.before_epoch) begin
					error_count++;
					$error("before_epoch: expected %0b, got %0b", want.before_epoch,
						before_epoch);
				end
			end
		end
	end

	// Abandon a run that hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_dates();
		test_full_rate();
		test_back_pressure();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();

		// let the pipeline settle, then judge
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_dates.size() != 0) begin
			error_count++;
			$error("%0d expected results never arrived", pending_dates.size());
		end
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
